// File: sv/assert_macros.svh
// Assertion macros shared by the MPEG audio header sync block.
// Each macro expects signals named clk and rst in the scope of its use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds in a cycle, consequent holds in the same cycle.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent holds in a cycle, consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/mahsd_pkg.sv
// Package for the MPEG audio header sync and decode block.
// Holds constants, bitrate and sample-rate tables and the control structs.
// No dependencies.
package mahsd_pkg;

  localparam logic [31:0] RESET_MASK = 32'hffe0_0000;
  localparam logic [2:0]  COUNT_SAT  = 3'd5;
  localparam logic [2:0]  RESYNC_MIN = 3'd4;

  localparam int L1_SCALE  = 12000;
  localparam int L23_SCALE = 144000;
  localparam int SCALE_W   = 18;

  localparam int DIV_W   = 26;
  localparam int DIVR_W  = 16;
  localparam int DCNT_W  = $clog2(DIV_W);
  localparam int FRAME_W = DIV_W + 3;

  localparam logic [10:0] FIELD11_MAX = 11'd2047;

  localparam logic [5:0] SIDE_V1_MONO   = 6'd17;
  localparam logic [5:0] SIDE_V1_STEREO = 6'd32;
  localparam logic [5:0] SIDE_V2_MONO   = 6'd9;
  localparam logic [5:0] SIDE_V2_STEREO = 6'd17;
  localparam logic [5:0] HEADER_BYTES   = 6'd4;
  localparam logic [5:0] CRC_BYTES      = 6'd2;

  localparam logic [1:0] VER_MPEG1    = 2'd3;
  localparam logic [1:0] VER_RESERVED = 2'd1;
  localparam logic [1:0] LAYER_CODE_RESERVED = 2'd0;
  localparam logic [1:0] MODE_JOINT   = 2'd1;
  localparam logic [1:0] MODE_MONO    = 2'd3;
  localparam logic [1:0] SIDX_RESERVED = 2'd3;
  localparam logic [3:0] BIDX_FREE    = 4'h0;
  localparam logic [3:0] BIDX_BAD     = 4'hf;

  localparam logic [8:0] KBPS_V1_L1 [16] = '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160,
    9'd192, 9'd224, 9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
  localparam logic [8:0] KBPS_V1_L2 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
    9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
  localparam logic [8:0] KBPS_V1_L3 [16] = '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64,
    9'd80, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
  localparam logic [8:0] KBPS_V2_L1 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
    9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
  localparam logic [8:0] KBPS_V2_L23 [16] = '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40,
    9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

  // Layer is given as the decoded number 1, 2 or 3.
  function automatic logic [8:0] kbps_lookup(input logic lsf, input logic [1:0] layer,
                                             input logic [3:0] bidx);
    logic [8:0] k;
    if (!lsf) begin
      case (layer)
        2'd1:    k = KBPS_V1_L1[bidx];
        2'd2:    k = KBPS_V1_L2[bidx];
        default: k = KBPS_V1_L3[bidx];
      endcase
    end else begin
      case (layer)
        2'd1:    k = KBPS_V2_L1[bidx];
        default: k = KBPS_V2_L23[bidx];
      endcase
    end
    return k;
  endfunction

  function automatic logic [15:0] rate_lookup(input logic [1:0] ver, input logic [1:0] sidx);
    logic [15:0] r;
    case ({ver, sidx})
      4'b00_00: r = 16'd11025;
      4'b00_01: r = 16'd12000;
      4'b00_10: r = 16'd8000;
      4'b10_00: r = 16'd22050;
      4'b10_01: r = 16'd24000;
      4'b10_10: r = 16'd16000;
      4'b11_00: r = 16'd44100;
      4'b11_01: r = 16'd48000;
      4'b11_10: r = 16'd32000;
      default:  r = 16'd0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic take_byte;
    logic mul_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic div_last;
  } status_t;

endpackage

// File: sv/mahsd_ctrl.sv
// Controller of the MPEG audio header block: sequences byte intake,
// scaling, division and result load. Depends on mahsd_pkg.
module mahsd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  mahsd_pkg::status_t status,
  output mahsd_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        cmd.take_byte = in_valid;
        if (in_valid && status.match) state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = ST_FIN;
      end
      ST_FIN: begin
        // The result waits here until the output register is free.
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) out_valid_next = 1'b1;
    else if (!out_stall) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: sv/mahsd_datapath.sv
// Datapath of the MPEG audio header block: byte window, header check,
// field decode, restoring divider and result registers. Depends on mahsd_pkg.
module mahsd_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         data_byte,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  mahsd_pkg::cmd_t    cmd,
  output mahsd_pkg::status_t status,
  output logic [1:0]         version_id,
  output logic [1:0]         layer_number,
  output logic               crc_present,
  output logic [8:0]         bitrate_kbps,
  output logic [15:0]        sample_rate_hz,
  output logic [1:0]         channel_mode,
  output logic               ms_stereo,
  output logic               intensity_stereo,
  output logic [10:0]        frame_bytes,
  output logic [5:0]         side_info_bytes,
  output logic [10:0]        main_data_bytes,
  output logic               resynced
);

  localparam int DIV_W  = mahsd_pkg::DIV_W;
  localparam int DIVR_W = mahsd_pkg::DIVR_W;
  localparam int FRAME_W = mahsd_pkg::FRAME_W;
  localparam int SCALE_PROD_W = 9 + mahsd_pkg::SCALE_W;

  logic [31:0] sync_mask;
  logic [31:0] byte_window;
  logic [2:0]  bytes_since_header;

  logic [31:0] win_next;
  logic [2:0]  count_next;
  logic        header_ok;

  // Decoded header, held while the frame length is worked out.
  logic [1:0]  hdr_ver;
  logic [1:0]  hdr_layer;
  logic        hdr_prot;
  logic [8:0]  hdr_kbps;
  logic [15:0] hdr_hz;
  logic        hdr_pad;
  logic [1:0]  hdr_mode;
  logic [1:0]  hdr_mext;
  logic        hdr_resync;

  logic [DIV_W-1:0]        quo;
  logic [DIVR_W-1:0]       rem;
  logic [DIVR_W-1:0]       divisor;
  logic [mahsd_pkg::DCNT_W-1:0] div_cnt;

  logic [DIVR_W:0]         trial;
  logic                    trial_ge;
  logic [SCALE_PROD_W-1:0] product;
  logic [DIVR_W:0]         divisor_wide;
  logic                    lsf;

  logic [FRAME_W-1:0] frame_raw;
  logic [FRAME_W-1:0] main_raw;
  logic [5:0]         side;
  logic [5:0]         overhead;

  assign win_next   = {byte_window[23:0], data_byte};
  assign count_next = (bytes_since_header < mahsd_pkg::COUNT_SAT) ?
                      bytes_since_header + 3'd1 : bytes_since_header;

  assign header_ok = ((win_next & sync_mask) == sync_mask)
                  && (win_next[20:19] != mahsd_pkg::VER_RESERVED)
                  && (win_next[18:17] != mahsd_pkg::LAYER_CODE_RESERVED)
                  && (win_next[15:12] != mahsd_pkg::BIDX_BAD)
                  && (win_next[15:12] != mahsd_pkg::BIDX_FREE)
                  && (win_next[11:10] != mahsd_pkg::SIDX_RESERVED);

  assign status.match    = header_ok;
  assign status.div_last = (div_cnt == mahsd_pkg::DCNT_W'(DIV_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_mask          <= mahsd_pkg::RESET_MASK;
      byte_window        <= '0;
      bytes_since_header <= '0;
    end else begin
      if (cfg_wr_en) sync_mask <= cfg_wr_data;
      if (cmd.take_byte) begin
        if (header_ok) begin
          byte_window        <= '0;
          bytes_since_header <= '0;
        end else begin
          byte_window        <= win_next;
          bytes_since_header <= count_next;
        end
      end
    end
  end

  // Header fields are captured from the window that completes the match.
  always_ff @(posedge clk) begin
    if (cmd.take_byte && header_ok) begin
      hdr_ver    <= win_next[20:19];
      hdr_layer  <= 2'd0 - win_next[18:17];
      hdr_prot   <= win_next[16];
      hdr_kbps   <= mahsd_pkg::kbps_lookup(win_next[20:19] != mahsd_pkg::VER_MPEG1,
                                           2'd0 - win_next[18:17], win_next[15:12]);
      hdr_hz     <= mahsd_pkg::rate_lookup(win_next[20:19], win_next[11:10]);
      hdr_pad    <= win_next[9];
      hdr_mode   <= win_next[7:6];
      hdr_mext   <= win_next[5:4];
      hdr_resync <= (count_next > mahsd_pkg::RESYNC_MIN);
    end
  end

  assign lsf = (hdr_ver != mahsd_pkg::VER_MPEG1);

  always_comb begin
    if (hdr_layer == 2'd1)
      product = hdr_kbps * mahsd_pkg::SCALE_W'(mahsd_pkg::L1_SCALE);
    else
      product = hdr_kbps * mahsd_pkg::SCALE_W'(mahsd_pkg::L23_SCALE);
  end

  // Layer III at the lower rates halves the sample count per frame.
  assign divisor_wide = {1'b0, hdr_hz} << ((hdr_layer == 2'd3) && lsf);

  assign trial    = {rem, quo[DIV_W-1]};
  assign trial_ge = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      quo     <= product[DIV_W-1:0];
      rem     <= '0;
      divisor <= divisor_wide[DIVR_W-1:0];
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      // One quotient bit per cycle, restoring form.
      if (trial_ge) begin
        rem <= DIVR_W'(trial - {1'b0, divisor});
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= trial[DIVR_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
      div_cnt <= div_cnt + 1'b1;
    end
  end

  always_comb begin
    side = '0;
    if (hdr_layer == 2'd3) begin
      if (!lsf)
        side = (hdr_mode == mahsd_pkg::MODE_MONO) ? mahsd_pkg::SIDE_V1_MONO :
                                                    mahsd_pkg::SIDE_V1_STEREO;
      else
        side = (hdr_mode == mahsd_pkg::MODE_MONO) ? mahsd_pkg::SIDE_V2_MONO :
                                                    mahsd_pkg::SIDE_V2_STEREO;
    end
    overhead = mahsd_pkg::HEADER_BYTES + side + (hdr_prot ? 6'd0 : mahsd_pkg::CRC_BYTES);
    if (hdr_layer == 2'd1)
      frame_raw = (FRAME_W'(quo) + FRAME_W'(hdr_pad)) << 2;
    else
      frame_raw = FRAME_W'(quo) + FRAME_W'(hdr_pad);
    main_raw = (frame_raw > FRAME_W'(overhead)) ? frame_raw - FRAME_W'(overhead) : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      version_id       <= hdr_ver;
      layer_number     <= hdr_layer;
      crc_present      <= !hdr_prot;
      bitrate_kbps     <= hdr_kbps;
      sample_rate_hz   <= hdr_hz;
      channel_mode     <= hdr_mode;
      ms_stereo        <= (hdr_mode == mahsd_pkg::MODE_JOINT) && hdr_mext[1];
      intensity_stereo <= (hdr_mode == mahsd_pkg::MODE_JOINT) && hdr_mext[0];
      frame_bytes      <= (frame_raw > FRAME_W'(mahsd_pkg::FIELD11_MAX)) ?
                          mahsd_pkg::FIELD11_MAX : frame_raw[10:0];
      side_info_bytes  <= side;
      main_data_bytes  <= (main_raw > FRAME_W'(mahsd_pkg::FIELD11_MAX)) ?
                          mahsd_pkg::FIELD11_MAX : main_raw[10:0];
      resynced         <= hdr_resync;
    end
  end

endmodule

// File: sv/mpeg_audio_header_sync_decode_top.sv
// Top level of the MPEG audio header sync and decode block.
// Joins mahsd_ctrl and mahsd_datapath; uses mahsd_pkg and assert_macros.svh.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  data_byte
//   out      out_valid/ out_stall decoded header fields, one beat per header
//   cfg      cfg_wr_en            cfg_wr_data (sync mask)
//
// A byte that completes no header streams in at one per cycle while no header is busy.
// A byte that completes a header is decoded, then the bitrate is scaled, the divider
// finds the frame length one bit per cycle, and the result is loaded once the output
// register is free; input is stalled until that load. Reset is synchronous and leaves the
// mask at its default; a stalled result holds and the next header waits for it.
`include "assert_macros.svh"

module mpeg_audio_header_sync_decode_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  version_id,
  output logic [1:0]  layer_number,
  output logic        crc_present,
  output logic [8:0]  bitrate_kbps,
  output logic [15:0] sample_rate_hz,
  output logic [1:0]  channel_mode,
  output logic        ms_stereo,
  output logic        intensity_stereo,
  output logic [10:0] frame_bytes,
  output logic [5:0]  side_info_bytes,
  output logic [10:0] main_data_bytes,
  output logic        resynced
);

  mahsd_pkg::cmd_t    cmd;
  mahsd_pkg::status_t status;

  mahsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mahsd_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .data_byte        (data_byte),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .cmd              (cmd),
    .status           (status),
    .version_id       (version_id),
    .layer_number     (layer_number),
    .crc_present      (crc_present),
    .bitrate_kbps     (bitrate_kbps),
    .sample_rate_hz   (sample_rate_hz),
    .channel_mode     (channel_mode),
    .ms_stereo        (ms_stereo),
    .intensity_stereo (intensity_stereo),
    .frame_bytes      (frame_bytes),
    .side_info_bytes  (side_info_bytes),
    .main_data_bytes  (main_data_bytes),
    .resynced         (resynced)
  );

  // A header beat must hold off further bytes while its length is worked out.
  `ASSERT_NEXT(a_hdr_stall, in_valid && !in_stall && status.match, in_stall, "header not held")
  `ASSERT_SAME(a_main_le_frame, out_valid, main_data_bytes <= frame_bytes, "main data too long")
  `ASSERT_SAME(a_side, out_valid && layer_number != 2'd3, side_info_bytes == '0, "stray side info")
  `ASSERT_SAME(a_load_only_free, cmd.out_load, !out_valid || !out_stall, "load over waiting beat")

endmodule
